// ----- rtl/core/mkse_pkg.sv -----
// Package for the keypad scanner with event ring: command codes, key map,
// lane result and ring request/response types. No dependencies.
package mkse_pkg;

	localparam int ROWS = 4;

	localparam logic [1:0] CMD_SCAN = 2'd0;
	localparam logic [1:0] CMD_RISE = 2'd1;
	localparam logic [1:0] CMD_POP  = 2'd2;

	localparam logic [7:0] KEY_MAP [16] = '{
		8'h44, 8'h43, 8'h42, 8'h41, 8'h23, 8'h39, 8'h36, 8'h33,
		8'h30, 8'h38, 8'h35, 8'h32, 8'h2A, 8'h37, 8'h34, 8'h31
	};

	typedef struct packed {
		logic       up_hit;
		logic       down_hit;
		logic [7:0] key;
	} lane_t;

	typedef struct packed {
		logic                  step;
		logic                  pop;
		logic [ROWS-1:0]       mask;
		logic [ROWS-1:0][8:0]  data;
	} ring_req_t;

	typedef struct packed {
		logic       valid;
		logic       pressed;
		logic [7:0] key;
	} ring_ev_t;

endpackage

// ----- rtl/core/mkse_if.sv -----
// Channel interfaces for the keypad scanner: command beats in, result beats out.
// Depends on nothing.
interface mkse_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] row_levels;
	logic [3:0] rising_rows;

	modport source (output valid, command, row_levels, rising_rows, input ready);
	modport sink   (input valid, command, row_levels, rising_rows, output ready);
endinterface

interface mkse_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] active_column;
	logic       column_running;
	logic       event_valid;
	logic       event_pressed;
	logic [7:0] event_key;
	logic [4:0] queue_count;

	modport source (output valid, active_column, column_running, event_valid,
		event_pressed, event_key, queue_count, input ready);
	modport sink   (input valid, active_column, column_running, event_valid,
		event_pressed, event_key, queue_count, output ready);
endinterface

// ----- rtl/core/mkse_lane.sv -----
// One row lane: release and press detection for the key of the driven column.
// Depends on mkse_pkg.
module mkse_lane (
	input  logic          [1:0]  row,
	input  logic          [1:0]  command,
	input  logic                 started,
	input  logic          [1:0]  column,
	input  logic          [15:0] key_down,
	input  logic                 level,
	input  logic          [3:0]  rising,
	output mkse_pkg::lane_t      res
);
	import mkse_pkg::*;

	logic [3:0] kidx;
	logic       down;
	logic [3:0] lower;

	assign kidx  = {column, row};
	assign down  = key_down[kidx];
	assign lower = rising & ((4'b0001 << row) - 4'b0001);

	assign res.up_hit   = started && (command == CMD_SCAN) && !level && down;
	assign res.down_hit = started && (command == CMD_RISE) && rising[row] &&
		(lower == 4'b0000) && !down;
	assign res.key      = KEY_MAP[kidx];
endmodule

// ----- rtl/core/mkse_ring.sv -----
// Event ring: four banks written in parallel, ordered by rank, one read per beat.
// Depends on mkse_pkg.
module mkse_ring #(
	parameter int RING_DEPTH = 32,
	parameter int CW         = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mkse_pkg::ring_req_t req,
	output logic [CW-1:0]       count_next,
	output logic [CW-1:0]       count,
	output mkse_pkg::ring_ev_t  ev
);
	import mkse_pkg::*;

	localparam int BANK_DEPTH = (RING_DEPTH + 3) / 4;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int PW         = AW + 2;
	localparam int PHYS       = BANK_DEPTH * 4;
	localparam logic [PW:0]   PHYS_W = (PW+1)'(PHYS);
	localparam logic [CW-1:0] CAP    = CW'(RING_DEPTH - 1);

	logic [8:0]    ring_mem_q [4][BANK_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic [3:0][8:0] rd_q;
	logic [1:0]    rd_bank_q;
	logic          hit_q;

	logic [CW-1:0]      space;
	logic [ROWS-1:0][2:0] rank;
	logic [ROWS-1:0]    keep;
	logic [2:0]         n_push;
	logic [3:0]         wen;
	logic [3:0][8:0]    wdata;
	logic [3:0][AW-1:0] waddr;
	logic               pop_ok;
	logic [PW-1:0]      wptr_next, rptr_next;
	logic [PW:0]        wsum, rsum;

	always_comb begin
		logic [2:0] acc;
		acc    = 3'd0;
		n_push = 3'd0;
		space  = CAP - count_q;
		for (int r = 0; r < ROWS; r++) begin
			rank[r] = acc;
			keep[r] = req.step && req.mask[r] &&
				((CW+3)'(acc) < (CW+3)'(space));
			acc     = acc + 3'(req.mask[r]);
			n_push  = n_push + 3'(keep[r]);
		end
	end

	always_comb begin
		logic [1:0]  j;
		logic [PW:0] pos;
		for (int b = 0; b < 4; b++) begin
			j   = 2'(b) - wptr_q[1:0];
			pos = {1'b0, wptr_q} + (PW+1)'(j);
			if (pos >= PHYS_W) begin
				pos = pos - PHYS_W;
			end
			waddr[b] = pos[PW-1:2];
			wen[b]   = 1'b0;
			wdata[b] = '0;
			for (int r = 0; r < ROWS; r++) begin
				if (keep[r] && (rank[r] == {1'b0, j})) begin
					wen[b]   = 1'b1;
					wdata[b] = req.data[r];
				end
			end
		end
	end

	assign pop_ok = req.step && req.pop && (count_q != '0);

	always_comb begin
		wsum = {1'b0, wptr_q} + (PW+1)'(n_push);
		if (wsum >= PHYS_W) begin
			wsum = wsum - PHYS_W;
		end
		rsum = {1'b0, rptr_q} + (PW+1)'(pop_ok);
		if (rsum >= PHYS_W) begin
			rsum = rsum - PHYS_W;
		end
		wptr_next  = wsum[PW-1:0];
		rptr_next  = rsum[PW-1:0];
		count_next = count_q + CW'(n_push) - CW'(pop_ok);
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (wen[b]) begin
				ring_mem_q[b][waddr[b]] <= wdata[b];
			end
		end
		if (pop_ok) begin
			for (int b = 0; b < 4; b++) begin
				rd_q[b] <= ring_mem_q[b][rptr_q[PW-1:2]];
			end
			rd_bank_q <= rptr_q[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else if (req.step) begin
			wptr_q  <= wptr_next;
			rptr_q  <= rptr_next;
			count_q <= count_next;
			hit_q   <= pop_ok;
		end
	end

	assign count      = count_q;
	assign ev.valid   = hit_q;
	assign ev.pressed = hit_q & rd_q[rd_bank_q][8];
	assign ev.key     = hit_q ? rd_q[rd_bank_q][7:0] : 8'h00;
endmodule

// ----- rtl/core/matrix_keypad_scanner_event_fifo.sv -----
// Top level of the 4x4 keypad scanner with event ring: column state, key flags,
// four row lanes, the ring and the result register. Depends on mkse_pkg, mkse_if.
//
//  channel | dir | beat
//  req     | in  | command, row_levels, rising_rows
//  rsp     | out | active_column, column_running, event_*, queue_count
//
// One command beat per cycle while results are taken; its result appears the cycle after acceptance.
// The four lanes and the four ring banks let a scan tick queue up to four
// releases in that single cycle; a pop reads one bank entry into the result.
// Reset clears column state, key flags and ring pointers; ring contents stay.
// A stalled result holds; req stays ready while the result is taken that cycle.
module matrix_keypad_scanner_event_fifo #(
	parameter int RING_DEPTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	mkse_req_if.sink   req,
	mkse_rsp_if.source rsp
);
	import mkse_pkg::*;

	localparam int CW = $clog2(RING_DEPTH);

	logic          accept;
	logic [1:0]    column_q;
	logic          started_q;
	logic [15:0]   key_down_q;
	logic [15:0]   key_down_next;
	logic          rsp_valid_q;
	logic [1:0]    column_s1;
	logic          started_s1;
	logic [4:0]    count_s1;
	lane_t         lane [ROWS];
	ring_req_t     ring_req;
	ring_ev_t      ring_ev;
	logic [CW-1:0] count_next, count_now;
	logic [CW+4:0] count_ext;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		mkse_lane u_lane (
			.row      (2'(r)),
			.command  (req.command),
			.started  (started_q),
			.column   (column_q),
			.key_down (key_down_q),
			.level    (req.row_levels[r]),
			.rising   (req.rising_rows),
			.res      (lane[r])
		);
	end

	always_comb begin
		key_down_next = key_down_q;
		ring_req.step = accept;
		ring_req.pop  = (req.command == CMD_POP);
		for (int r = 0; r < ROWS; r++) begin
			ring_req.mask[r] = lane[r].up_hit || lane[r].down_hit;
			ring_req.data[r] = {lane[r].down_hit, lane[r].key};
			if (lane[r].up_hit) begin
				key_down_next[{column_q, 2'(r)}] = 1'b0;
			end
			if (lane[r].down_hit) begin
				key_down_next[{column_q, 2'(r)}] = 1'b1;
			end
		end
	end

	mkse_ring #(
		.RING_DEPTH (RING_DEPTH),
		.CW         (CW)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ring_req),
		.count_next (count_next),
		.count      (count_now),
		.ev         (ring_ev)
	);

	assign count_ext = (CW+5)'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= 2'd0;
			started_q   <= 1'b0;
			key_down_q  <= 16'h0000;
			rsp_valid_q <= 1'b0;
			column_s1   <= 2'd0;
			started_s1  <= 1'b0;
			count_s1    <= 5'd0;
		end else begin
			if (accept) begin
				key_down_q <= key_down_next;
				if (req.command == CMD_SCAN) begin
					column_q  <= column_q + 2'(started_q);
					started_q <= 1'b1;
					column_s1 <= column_q + 2'(started_q);
				end else begin
					column_s1 <= column_q;
				end
				started_s1 <= started_q || (req.command == CMD_SCAN);
				count_s1   <= count_ext[4:0];
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.active_column  = column_s1;
	assign rsp.column_running = started_s1;
	assign rsp.event_valid    = ring_ev.valid;
	assign rsp.event_pressed  = ring_ev.pressed;
	assign rsp.event_key      = ring_ev.key;
	assign rsp.queue_count    = count_s1;

	a_ring_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(count_now) <= (CW+1)'(RING_DEPTH - 1))
		else $error("ring count beyond capacity");

	a_event_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.command != CMD_POP) |=> !rsp.event_valid)
		else $error("event reported for a non-pop beat");

	a_running: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("column scan stopped");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.command == CMD_SCAN) |=> started_q && rsp.column_running)
		else $error("scan tick did not start the column scan");
endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for the 4x4 keypad scanner with event ring: a directed
// opening then random scan/press/pop traffic with idling on both channels.
// Depends on mkse_pkg, mkse_if and matrix_keypad_scanner_event_fifo.
module tb_top;
	import mkse_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int RING_SLOTS = 31;
	localparam int TAIL_BEATS = 300;

	localparam logic [7:0] KEYCAP [16] = '{
		"D", "C", "B", "A", "#", "9", "6", "3",
		"0", "8", "5", "2", "*", "7", "4", "1"
	};

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] levels;
		logic [3:0] rising;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0] column;
		logic       running;
		logic       ev_valid;
		logic       ev_pressed;
		logic [7:0] key;
		logic [4:0] count;
	} scan_result_t;

	logic clk;
	logic arst_n;

	mkse_req_if req_ch ();
	mkse_rsp_if rsp_ch ();

	matrix_keypad_scanner_event_fifo u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	cmd_beat_t    cmd_backlog [$];
	scan_result_t pending_results [$];
	logic [8:0]   key_events [$];
	logic [1:0]   col_now;
	logic         col_live;
	logic [15:0]  keys_held;

	int  total_beats;
	int  accepted;
	int  gap_left;
	int  stall_left;
	int  mismatches;
	int  unexpected;
	int  presses_seen;
	int  releases_seen;
	int  empty_pops;
	int  peak_count;
	logic hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5000000;
		$display("[matrix_keypad_scanner_event_fifo] ERROR");
		$finish;
	end

	function automatic void push_key_event(logic [8:0] ev);
		if (key_events.size() < RING_SLOTS)
			key_events.push_back(ev);
	endfunction

	task automatic keypad_step(input cmd_beat_t b);
		scan_result_t r;
		logic [3:0]   k;
		logic [8:0]   ev;
		int           row;
		r = '0;
		case (b.command)
			CMD_SCAN: begin
				if (col_live) begin
					for (int i = 0; i < 4; i++) begin
						k = {col_now, i[1:0]};
						if (!b.levels[i] && keys_held[k]) begin
							keys_held[k] = 1'b0;
							push_key_event({1'b0, KEYCAP[k]});
						end
					end
					col_now = col_now + 2'd1;
				end else begin
					col_now = 2'd0;
					col_live = 1'b1;
				end
			end
			CMD_RISE: begin
				if (col_live && b.rising != 4'h0) begin
					row = 0;
					while (row < 3 && !b.rising[row])
						row++;
					k = {col_now, row[1:0]};
					if (!keys_held[k]) begin
						keys_held[k] = 1'b1;
						push_key_event({1'b1, KEYCAP[k]});
					end
				end
			end
			CMD_POP: begin
				if (key_events.size() > 0) begin
					ev = key_events.pop_front();
					r.ev_valid = 1'b1;
					r.ev_pressed = ev[8];
					r.key = ev[7:0];
				end else begin
					empty_pops++;
				end
			end
			default: ;
		endcase
		r.column = col_now;
		r.running = col_live;
		r.count = 5'(key_events.size());
		pending_results.push_back(r);
	endtask

	task automatic queue_beat(input logic [1:0] cmd, input logic [3:0] lv,
		input logic [3:0] rr);
		cmd_beat_t b;
		b.command = cmd;
		b.levels = lv;
		b.rising = rr;
		cmd_backlog.push_back(b);
	endtask

	function automatic cmd_beat_t random_beat(int pop_pct);
		cmd_beat_t b;
		int r;
		r = $urandom_range(99);
		if (r < pop_pct)
			b.command = CMD_POP;
		else if (r < 97)
			b.command = ($urandom_range(1) == 0) ? CMD_SCAN : CMD_RISE;
		else
			b.command = CMD_NONE;
		case ($urandom_range(3))
			0: b.levels = 4'($urandom_range(15));
			1: b.levels = 4'hF;
			default: b.levels = ~(4'b0001 << $urandom_range(3));
		endcase
		if ($urandom_range(3) == 0)
			b.rising = 4'($urandom_range(15));
		else
			b.rising = 4'b0001 << $urandom_range(3);
		return b;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= CMD_SCAN;
			req_ch.row_levels <= 4'h0;
			req_ch.rising_rows <= 4'h0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				keypad_step({req_ch.command, req_ch.row_levels, req_ch.rising_rows});
				accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_beat_t b;
					b = cmd_backlog.pop_front();
					req_ch.command <= b.command;
					req_ch.row_levels <= b.levels;
					req_ch.rising_rows <= b.rising;
					req_ch.valid <= 1'b1;
					if (cmd_backlog.size() > TAIL_BEATS && $urandom_range(7) == 0)
						gap_left = $urandom_range(1, 15);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_result;
		scan_result_t want;
		scan_result_t got;
		got = {rsp_ch.active_column, rsp_ch.column_running, rsp_ch.event_valid,
			rsp_ch.event_pressed, rsp_ch.event_key, rsp_ch.queue_count};
		if (pending_results.size() == 0) begin
			unexpected++;
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: col=%0d run=%0b ev=%0b/%0b ",
					"key=%02h cnt=%0d",
					got.column, got.running, got.ev_valid, got.ev_pressed, got.key, got.count);
			return;
		end
		want = pending_results.pop_front();
		if (got.column !== want.column || got.running !== want.running
				|| got.ev_valid !== want.ev_valid || got.ev_pressed !== want.ev_pressed
				|| got.key !== want.key || got.count !== want.count) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: want col=%0d run=%0b ev=%0b/%0b key=%02h cnt=%0d, ",
					"got col=%0d run=%0b ev=%0b/%0b key=%02h cnt=%0d",
					$time, want.column, want.running, want.ev_valid, want.ev_pressed,
					want.key, want.count, got.column, got.running, got.ev_valid,
					got.ev_pressed, got.key, got.count);
		end
		if (got.ev_valid === 1'b1) begin
			if (got.ev_pressed === 1'b1)
				presses_seen++;
			else
				releases_seen++;
		end
		if (got.count > peak_count)
			peak_count = got.count;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (accepted < total_beats - TAIL_BEATS && $urandom_range(9) == 0) begin
				stall_left = $urandom_range(0, 14);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		hold_off = 1'b0;
		while (accepted < 700) @(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : stimulus
		int pop_pct;
		col_now = 2'd0;
		col_live = 1'b0;
		keys_held = 16'h0;
		accepted = 0;
		mismatches = 0;
		unexpected = 0;
		presses_seen = 0;
		releases_seen = 0;
		empty_pops = 0;
		peak_count = 0;
		total_beats = 1 << 30;

		queue_beat(CMD_RISE, 4'h0, 4'b0001);
		queue_beat(CMD_POP,  4'h0, 4'h0);
		queue_beat(CMD_NONE, 4'hF, 4'hF);
		queue_beat(CMD_SCAN, 4'h0, 4'h0);
		queue_beat(CMD_RISE, 4'hF, 4'h0);
		queue_beat(CMD_RISE, 4'hF, 4'b0110);
		queue_beat(CMD_RISE, 4'hF, 4'b0010);
		queue_beat(CMD_RISE, 4'hF, 4'b1000);
		queue_beat(CMD_RISE, 4'hF, 4'b0001);
		queue_beat(CMD_SCAN, 4'b0000, 4'h0);
		queue_beat(CMD_RISE, 4'h0, 4'hF);
		queue_beat(CMD_SCAN, 4'hF, 4'h0);
		queue_beat(CMD_SCAN, 4'hF, 4'h0);
		queue_beat(CMD_RISE, 4'h0, 4'b1000);
		queue_beat(CMD_SCAN, 4'hF, 4'hF);
		queue_beat(CMD_NONE, 4'h0, 4'h0);
		for (int i = 0; i < 9; i++)
			queue_beat(CMD_POP, 4'hF, 4'hF);

		for (int ph = 0; ph < 20; ph++) begin
			case ($urandom_range(3))
				0: pop_pct = 3;
				1: pop_pct = 25;
				2: pop_pct = 45;
				default: pop_pct = 80;
			endcase
			for (int i = 0; i < 100; i++)
				cmd_backlog.push_back(random_beat(pop_pct));
		end
		for (int i = 0; i < 40; i++)
			queue_beat(CMD_POP, 4'h0, 4'h0);
		total_beats = cmd_backlog.size();

		while (accepted < total_beats) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			mismatches++;

		$display("%0d command beats checked; %0d presses and %0d releases popped",
			total_beats, presses_seen, releases_seen);
		$display("%0d pops of an empty ring, peak ring occupancy %0d", empty_pops, peak_count);
		if (mismatches == 0) begin
			$display("[matrix_keypad_scanner_event_fifo] OK");
		end else begin
			$display("%0d mismatches (%0d unexpected beats)", mismatches, unexpected);
			$display("[matrix_keypad_scanner_event_fifo] ERROR");
		end
		$finish;
	end

endmodule
